// ===== hdl/ppi_pkg.sv =====
package ppi_pkg;

	// sizing
	localparam int CORDIC_STEPS = 24;
	localparam int POSE_BITS    = 48;
	localparam int ITER_W       = $clog2(CORDIC_STEPS);
	localparam int CW           = 34;
	localparam int PC_W         = 5;
	localparam int D_W          = 34;
	localparam int SUM_W        = ((POSE_BITS > D_W) ? POSE_BITS : D_W) + 1;
	localparam int DIVA_W       = 20;

	// heading constants, degrees Q16
	localparam logic signed [24:0] HALF_TURN_Q16 = 25'sd11796480;

	// CORDIC constants, Q4.30
	localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = CW'(652032874);
	localparam logic signed [CW-1:0] ONE_Q30         = CW'(1073741824);

	// reciprocals of 45: off / 45 = (off * M) >> 31, exact below 2^25
	localparam logic [25:0] DIV45_LONG_M  = 26'd47721859;
	localparam int          DIV45_LONG_SH = 31;
	// short form, exact below 2^14: (u * M) >> 20
	localparam logic [14:0] DIV45_SHORT_M = 15'd23302;
	localparam logic signed [15:0] WRAP_BIAS = 16'sd4140;

	// binary angle offsets (full and half angle)
	localparam logic [31:0] BA_BIAS_FULL = 32'h8000_0000;
	localparam logic [31:0] BA_BIAS_HALF = 32'hC000_0000;

	// rounding constant for Q30 products back to Q16
	localparam logic signed [63:0] RND_Q30 = 64'sd536870912;

	// arctangent table, binary angle units
	localparam logic [31:0][31:0] ATAN_BA = {
		32'h00000000, 32'h00000001, 32'h00000001, 32'h00000003,
		32'h00000005, 32'h0000000A, 32'h00000014, 32'h00000029,
		32'h00000051, 32'h000000A3, 32'h00000146, 32'h0000028C,
		32'h00000518, 32'h00000A30, 32'h0000145F, 32'h000028BE,
		32'h0000517D, 32'h0000A2FA, 32'h000145F3, 32'h00028BE6,
		32'h000517CC, 32'h000A2F98, 32'h00145F2F, 32'h0028BE53,
		32'h00517C55, 32'h00A2F61E, 32'h0145D7E1, 32'h028B0D43,
		32'h051111D4, 32'h09FB385B, 32'h12E4051E, 32'h20000000
	};

	// fractional part of the angle conversion for a remainder mod 45
	typedef logic [44:0][12:0] frac_tbl_t;

	function automatic frac_tbl_t build_frac_tbl(input int unsigned scale);
		frac_tbl_t t;
		for (int r = 0; r < 45; r++) begin
			t[r] = 13'((r * scale + 45) / 90);
		end
		return t;
	endfunction

	localparam frac_tbl_t FRAC_FULL = build_frac_tbl(16384);
	localparam frac_tbl_t FRAC_HALF = build_frac_tbl(8192);

	// datapath operations
	typedef enum logic [3:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_DIVMUL,
		OP_BA_FULL,
		OP_BA_HALF,
		OP_CINIT,
		OP_CITER,
		OP_SAVE_SC,
		OP_MUL_DXC,
		OP_LD_DYS,
		OP_SUB_DXS,
		OP_POSX_DYC,
		OP_ADD_ACC,
		OP_POSY,
		OP_YAW,
		OP_EMIT
	} op_t;

	// jump conditions
	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_INPUT,
		COND_OUT_BUSY,
		COND_NOT_LAST
	} cond_t;

	typedef struct packed {
		op_t              op;
		cond_t            cond;
		logic [PC_W-1:0]  target;
	} ctrl_word_t;

	typedef struct packed {
		logic in_valid;
		logic out_busy;
		logic cordic_last;
	} status_t;

	typedef struct packed {
		logic init;
		logic step;
	} cordic_cmd_t;

endpackage

// ===== hdl/ppi_in_if.sv =====
interface ppi_in_if import ppi_pkg::*; ();
	logic               valid;
	logic               ready;
	logic signed [31:0] delta_x;
	logic signed [31:0] delta_y;
	logic signed [31:0] delta_heading;

	modport source (output valid, output delta_x, output delta_y, output delta_heading,
		input ready);
	modport sink (input valid, input delta_x, input delta_y, input delta_heading,
		output ready);
endinterface

// ===== hdl/ppi_out_if.sv =====
interface ppi_out_if import ppi_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic signed [POSE_BITS-1:0] pose_x;
	logic signed [POSE_BITS-1:0] pose_y;
	logic signed [24:0]          heading;
	logic signed [31:0]          quat_z;
	logic signed [31:0]          quat_w;

	modport source (output valid, output pose_x, output pose_y, output heading,
		output quat_z, output quat_w, input ready);
	modport sink (input valid, input pose_x, input pose_y, input heading,
		input quat_z, input quat_w, output ready);
endinterface

// ===== hdl/ppi_sequencer.sv =====
module ppi_sequencer import ppi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  status_t    status,
	output ctrl_word_t ctrl
);

	// program addresses used as jump targets
	localparam logic [PC_W-1:0] ADDR_WAIT    = PC_W'(0);
	localparam logic [PC_W-1:0] ADDR_ITER1   = PC_W'(4);
	localparam logic [PC_W-1:0] ADDR_ITER2   = PC_W'(16);
	localparam logic [PC_W-1:0] ADDR_OUTWAIT = PC_W'(17);

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_d;
	logic            take_jump;

	// control store
	always_comb begin
		unique case (pc_q)
			PC_W'(0):  ctrl = '{OP_ACCEPT,   COND_NO_INPUT, ADDR_WAIT};
			PC_W'(1):  ctrl = '{OP_DIVMUL,   COND_NEVER,    ADDR_WAIT};
			PC_W'(2):  ctrl = '{OP_BA_FULL,  COND_NEVER,    ADDR_WAIT};
			PC_W'(3):  ctrl = '{OP_CINIT,    COND_NEVER,    ADDR_WAIT};
			PC_W'(4):  ctrl = '{OP_CITER,    COND_NOT_LAST, ADDR_ITER1};
			PC_W'(5):  ctrl = '{OP_SAVE_SC,  COND_NEVER,    ADDR_WAIT};
			PC_W'(6):  ctrl = '{OP_MUL_DXC,  COND_NEVER,    ADDR_WAIT};
			PC_W'(7):  ctrl = '{OP_LD_DYS,   COND_NEVER,    ADDR_WAIT};
			PC_W'(8):  ctrl = '{OP_SUB_DXS,  COND_NEVER,    ADDR_WAIT};
			PC_W'(9):  ctrl = '{OP_POSX_DYC, COND_NEVER,    ADDR_WAIT};
			PC_W'(10): ctrl = '{OP_ADD_ACC,  COND_NEVER,    ADDR_WAIT};
			PC_W'(11): ctrl = '{OP_POSY,     COND_NEVER,    ADDR_WAIT};
			PC_W'(12): ctrl = '{OP_YAW,      COND_NEVER,    ADDR_WAIT};
			PC_W'(13): ctrl = '{OP_DIVMUL,   COND_NEVER,    ADDR_WAIT};
			PC_W'(14): ctrl = '{OP_BA_HALF,  COND_NEVER,    ADDR_WAIT};
			PC_W'(15): ctrl = '{OP_CINIT,    COND_NEVER,    ADDR_WAIT};
			PC_W'(16): ctrl = '{OP_CITER,    COND_NOT_LAST, ADDR_ITER2};
			PC_W'(17): ctrl = '{OP_NOP,      COND_OUT_BUSY, ADDR_OUTWAIT};
			PC_W'(18): ctrl = '{OP_EMIT,     COND_ALWAYS,   ADDR_WAIT};
			default:   ctrl = '{OP_NOP,      COND_ALWAYS,   ADDR_WAIT};
		endcase
	end

	// jump condition
	always_comb begin
		unique case (ctrl.cond)
			COND_NEVER:    take_jump = 1'b0;
			COND_ALWAYS:   take_jump = 1'b1;
			COND_NO_INPUT: take_jump = !status.in_valid;
			COND_OUT_BUSY: take_jump = status.out_busy;
			COND_NOT_LAST: take_jump = !status.cordic_last;
			default:       take_jump = 1'b1;
		endcase
	end

	assign pc_d = take_jump ? ctrl.target : PC_W'(pc_q + 1'b1);

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ADDR_WAIT;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

// ===== hdl/ppi_cordic.sv =====
module ppi_cordic import ppi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cordic_cmd_t        cmd,
	input  logic [31:0]        ba,
	output logic signed [31:0] sin_q30,
	output logic signed [31:0] cos_q30,
	output logic               last
);

	logic signed [CW-1:0] x_q, y_q, z_q;
	logic [ITER_W-1:0]    iter_q;
	logic signed [CW-1:0] x_sh, y_sh, atan_v;
	logic                 fold;
	logic [31:0]          ba_fold;

	function automatic logic signed [31:0] clamp_q30(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] c;
		c = v;
		if (v > ONE_Q30) begin
			c = ONE_Q30;
		end else if (v < -ONE_Q30) begin
			c = -ONE_Q30;
		end
		return 32'(c);
	endfunction

	// quadrant fold: second and third quadrant rotate by half a turn
	assign fold    = (ba[31:30] == 2'b01) || (ba[31:30] == 2'b10);
	assign ba_fold = fold ? {~ba[31], ba[30:0]} : ba;

	// shifted terms for the current iteration
	assign x_sh   = x_q >>> iter_q;
	assign y_sh   = y_q >>> iter_q;
	assign atan_v = signed'(CW'(ATAN_BA[5'(iter_q)]));
	assign last   = (iter_q == ITER_W'(CORDIC_STEPS - 1));

	// rotation registers
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			x_q <= fold ? -CORDIC_GAIN_Q30 : CORDIC_GAIN_Q30;
			y_q <= '0;
			z_q <= CW'(signed'(ba_fold));
		end else if (cmd.step) begin
			if (!z_q[CW-1]) begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - atan_v;
			end else begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + atan_v;
			end
		end
	end

	// iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (cmd.init) begin
			iter_q <= '0;
		end else if (cmd.step) begin
			iter_q <= ITER_W'(iter_q + 1'b1);
		end
	end

	assign sin_q30 = clamp_q30(y_q);
	assign cos_q30 = clamp_q30(x_q);

endmodule

// ===== hdl/ppi_datapath.sv =====
module ppi_datapath import ppi_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ctrl_word_t                  ctrl,
	input  logic                        in_valid,
	input  logic signed [31:0]          delta_x,
	input  logic signed [31:0]          delta_y,
	input  logic signed [31:0]          delta_heading,
	input  logic signed [31:0]          sin_q30,
	input  logic signed [31:0]          cos_q30,
	input  logic                        out_ready,
	output logic [31:0]                 ba,
	output logic                        out_valid,
	output logic                        out_busy,
	output logic signed [POSE_BITS-1:0] pose_x,
	output logic signed [POSE_BITS-1:0] pose_y,
	output logic signed [24:0]          heading,
	output logic signed [31:0]          quat_z,
	output logic signed [31:0]          quat_w
);

	localparam logic signed [SUM_W-1:0] S_MAX =
		SUM_W'(signed'({1'b0, {(POSE_BITS-1){1'b1}}}));
	localparam logic signed [SUM_W-1:0] S_MIN =
		SUM_W'(signed'({1'b1, {(POSE_BITS-1){1'b0}}}));

	// latched increment
	logic signed [31:0] dx_q, dy_q, dh_q;
	// pose state
	logic signed [POSE_BITS-1:0] posx_q, posy_q;
	logic signed [24:0]          yaw_q;
	// working registers
	logic signed [31:0] sin_q, cos_q;
	logic signed [63:0] prod_q, acc_q;
	logic [24:0]        off_q;
	logic [31:0]        ba_q;
	logic               out_valid_q;
	logic signed [POSE_BITS-1:0] pose_x_q, pose_y_q;
	logic signed [24:0]          heading_q;
	logic signed [31:0]          quat_z_q, quat_w_q;

	// combinational terms
	logic signed [31:0] mul_a, mul_b;
	logic [24:0]        off_d;
	logic [DIVA_W-1:0]  div_a;
	logic [24:0]        div_a45;
	logic [5:0]         div_r;
	logic [31:0]        ba_full, ba_half;
	logic signed [D_W-1:0] acc_d;
	logic signed [33:0] wrap_t;
	logic signed [15:0] wrap_hi;
	logic [13:0]        wrap_u;
	logic [28:0]        wrap_p;
	logic [7:0]         wrap_qt;
	logic [13:0]        wrap_q45;
	logic [5:0]         wrap_r;
	logic signed [24:0] yaw_d;

	function automatic logic signed [POSE_BITS-1:0] sat_add(
		input logic signed [POSE_BITS-1:0] p,
		input logic signed [D_W-1:0]       d
	);
		logic signed [SUM_W-1:0] s;
		s = SUM_W'(p) + SUM_W'(d);
		if (s > S_MAX) begin
			s = S_MAX;
		end else if (s < S_MIN) begin
			s = S_MIN;
		end
		return POSE_BITS'(s);
	endfunction

	// heading offset into [0, full turn)
	assign off_d = unsigned'(yaw_q) + unsigned'(HALF_TURN_Q16);

	// multiplier operand select
	always_comb begin
		unique case (ctrl.op)
			OP_DIVMUL: begin
				mul_a = signed'({7'b0, off_d});
				mul_b = signed'({6'b0, DIV45_LONG_M});
			end
			OP_MUL_DXC: begin
				mul_a = dx_q;
				mul_b = cos_q;
			end
			OP_LD_DYS: begin
				mul_a = dy_q;
				mul_b = sin_q;
			end
			OP_SUB_DXS: begin
				mul_a = dx_q;
				mul_b = sin_q;
			end
			OP_POSX_DYC: begin
				mul_a = dy_q;
				mul_b = cos_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// binary angle: 8192 or 4096 per multiple of 45, table for the remainder
	assign div_a   = prod_q[DIV45_LONG_SH +: DIVA_W];
	assign div_a45 = 25'(div_a) * 25'd45;
	assign div_r   = 6'(off_q - div_a45);
	assign ba_full = 32'({div_a, 13'b0}) + 32'(FRAC_FULL[div_r]) + BA_BIAS_FULL;
	assign ba_half = 32'({div_a, 12'b0}) + 32'(FRAC_HALF[div_r]) + BA_BIAS_HALF;

	// rounded rotated increment, Q16
	assign acc_d = signed'(acc_q[63:30]);

	// heading wrap: full turn is 45 * 2^19, so only the upper bits need mod 45
	assign wrap_t   = 34'(yaw_q) + 34'(dh_q) + 34'(HALF_TURN_Q16);
	assign wrap_hi  = 16'(signed'(wrap_t[33:19]));
	assign wrap_u   = 14'(wrap_hi + WRAP_BIAS);
	assign wrap_p   = 29'(wrap_u) * 29'(DIV45_SHORT_M);
	assign wrap_qt  = wrap_p[27:20];
	assign wrap_q45 = 14'(wrap_qt) * 14'd45;
	assign wrap_r   = 6'(wrap_u - wrap_q45);
	assign yaw_d    = signed'(25'({wrap_r, wrap_t[18:0]}) - unsigned'(HALF_TURN_Q16));

	// working and output payload registers
	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
		case (ctrl.op)
			OP_ACCEPT: begin
				if (in_valid) begin
					dx_q <= delta_x;
					dy_q <= delta_y;
					dh_q <= delta_heading;
				end
			end
			OP_DIVMUL:   off_q <= off_d;
			OP_BA_FULL:  ba_q  <= ba_full;
			OP_BA_HALF:  ba_q  <= ba_half;
			OP_SAVE_SC: begin
				sin_q <= sin_q30;
				cos_q <= cos_q30;
			end
			OP_LD_DYS:   acc_q <= prod_q + RND_Q30;
			OP_SUB_DXS:  acc_q <= acc_q - prod_q;
			OP_POSX_DYC: acc_q <= prod_q + RND_Q30;
			OP_ADD_ACC:  acc_q <= acc_q + prod_q;
			OP_EMIT: begin
				pose_x_q  <= posx_q;
				pose_y_q  <= posy_q;
				heading_q <= yaw_q;
				quat_z_q  <= sin_q30;
				quat_w_q  <= cos_q30;
			end
			default: ;
		endcase
	end

	// pose state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			posx_q      <= '0;
			posy_q      <= '0;
			yaw_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.op == OP_POSX_DYC) begin
				posx_q <= sat_add(posx_q, acc_d);
			end
			if (ctrl.op == OP_POSY) begin
				posy_q <= sat_add(posy_q, acc_d);
			end
			if (ctrl.op == OP_YAW) begin
				yaw_q <= yaw_d;
			end
			if (ctrl.op == OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign ba        = ba_q;
	assign out_valid = out_valid_q;
	assign out_busy  = out_valid_q && !out_ready;
	assign pose_x    = pose_x_q;
	assign pose_y    = pose_y_q;
	assign heading   = heading_q;
	assign quat_z    = quat_z_q;
	assign quat_w    = quat_w_q;

endmodule

// ===== hdl/planar_pose_integrator_core.sv =====
// Planar dead-reckoning integrator: each delta transaction (body-frame dx, dy in mm Q16
// and a heading step in degrees Q16) is rotated by the stored heading, added to the
// saturating position, and the heading is advanced and wrapped to [-180,180) degrees;
// each one yields a pose transaction with position, new heading and the heading
// quaternion z and w (Q2.30). Each transaction takes two passes through the single
// CORDIC iteration unit, run by the microcoded sequencer, between acceptance and the
// result register, and the sequencer then returns to the accept step; one
// delta is worked on at a time, and a finished pose waits in its output register
// while the next delta is taken and computed, the sequencer holding only at the
// result step if that pose has still not been taken.
module planar_pose_integrator_core import ppi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ppi_in_if.sink    delta,
	ppi_out_if.source pose
);

	ctrl_word_t         ctrl;
	status_t            status;
	cordic_cmd_t        cmd;
	logic [31:0]        ba;
	logic signed [31:0] sin_q30, cos_q30;
	logic               cordic_last;
	logic               out_busy;

	// status back to the sequencer
	assign status.in_valid    = delta.valid;
	assign status.out_busy    = out_busy;
	assign status.cordic_last = cordic_last;

	// CORDIC commands from the control word
	assign cmd.init = (ctrl.op == OP_CINIT);
	assign cmd.step = (ctrl.op == OP_CITER);

	assign delta.ready = (ctrl.op == OP_ACCEPT);

	ppi_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	ppi_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.ba      (ba),
		.sin_q30 (sin_q30),
		.cos_q30 (cos_q30),
		.last    (cordic_last)
	);

	ppi_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.in_valid      (delta.valid),
		.delta_x       (delta.delta_x),
		.delta_y       (delta.delta_y),
		.delta_heading (delta.delta_heading),
		.sin_q30       (sin_q30),
		.cos_q30       (cos_q30),
		.out_ready     (pose.ready),
		.ba            (ba),
		.out_valid     (pose.valid),
		.out_busy      (out_busy),
		.pose_x        (pose.pose_x),
		.pose_y        (pose.pose_y),
		.heading       (pose.heading),
		.quat_z        (pose.quat_z),
		.quat_w        (pose.quat_w)
	);

endmodule
